### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, clocked on the rising edge and off while reset is low.
`define LFU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lfu check failed");

// Implication in the same cycle.
`define LFU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lfu check failed");

// Implication checked in the next cycle.
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lfu check failed");

`endif

### rtl/lfu_pkg.sv
package lfu_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 64;
  localparam int COUNT_BITS = 16;

  // Fixed field widths of the channels and the register.
  localparam int KEY_W   = 64;
  localparam int DATA_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int CSIZE_W = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Slot address and fill count widths.
  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_BITS  = $clog2(CAPACITY + 1);

  localparam logic [0:0] ACT_LOOKUP = 1'b0;
  localparam logic [0:0] ACT_INSERT = 1'b1;

  localparam logic [0:0] REG_CACHE_SIZE = 1'b0;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [DATA_W-1:0]     handle;
    logic [DATA_W-1:0]     length;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic                 cmp_en;
    logic                 insert;
    logic                 first;
    logic [ADDR_BITS-1:0] idx;
  } scan_ctrl_t;

endpackage

### rtl/lfu_if.sv
interface lfu_req_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] content_handle;
  logic [DATA_W-1:0] content_length;

  modport source (output valid, action, key, content_handle, content_length, input ready);
  modport sink   (input valid, action, key, content_handle, content_length, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] stored_handle;
  logic [DATA_W-1:0] stored_length;
  logic              evicted;

  modport source (output valid, hit, slot, stored_handle, stored_length, evicted, input ready);
  modport sink   (input valid, hit, slot, stored_handle, stored_length, evicted, output ready);
endinterface

### rtl/lfu_store.sv
module lfu_store import lfu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  entry_t               wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output entry_t               rdata_o
);

  // Entries hold no reset; only written slots are ever read.
  entry_t mem [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lfu_scan.sv
module lfu_scan import lfu_pkg::*; (
  input  logic                 clk_i,
  input  scan_ctrl_t           ctrl_i,
  input  logic [KEY_BITS-1:0]  key_i,
  input  entry_t               entry_i,
  output logic                 match_o,
  output logic [ADDR_BITS-1:0] best_idx_o,
  output entry_t               best_entry_o
);

  logic [ADDR_BITS-1:0] best_idx_q;
  entry_t               best_entry_q;
  logic                 take;

  // One key comparator and one count comparator, applied to a single entry per cycle.
  assign match_o = ctrl_i.cmp_en && !ctrl_i.insert && (entry_i.key == key_i);

  always_comb begin
    if (ctrl_i.insert) begin
      take = ctrl_i.cmp_en && (ctrl_i.first || (entry_i.count < best_entry_q.count));
    end else begin
      take = match_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q   <= ctrl_i.idx;
      best_entry_q <= entry_i;
    end
  end

  assign best_idx_o   = best_idx_q;
  assign best_entry_o = best_entry_q;

endmodule

### rtl/lfu_cache_table.sv
// Fully associative cache table with least-frequently-used replacement.
// A lookup item scans the filled slots one per cycle for its key; on a hit
// it returns the slot and the stored payload and bumps that slot's use count,
// which saturates. An insert item fills the next empty slot while fewer slots
// than the configured size are filled, and otherwise scans slots 0 to size-1
// for the lowest use count (the lowest slot on a tie) and replaces that entry
// with a fresh one at count zero. Inserts never check for duplicate keys.
// The table takes one item at a time. An insert into an empty slot goes
// straight to the write-back state; a lookup scans the filled slots and
// stops at the slot that hits, and an evicting insert scans slots 0 to
// size-1 first. The result is loaded into the output register as the
// write-back state ends, at the same clock edge at which the table is ready
// again. The scan rate is set by the single registered read port of the
// entry memory, which feeds one key and count comparison per cycle. The
// write-back waits while the output register still holds an untaken
// result. The next item is accepted while a result still waits in the
// output register.
// The size register sits at byte address 0 of the APB port, resets to 16,
// and the table treats 0 as 1 and values above 16 as 16; it may only be
// written while the table is idle.
module lfu_cache_table import lfu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfu_req_if.sink           req_i,
  lfu_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CSIZE_W-1:0]   size_cfg_q;
  logic [IDX_BITS-1:0]  valid_cnt_q, valid_cnt_d;
  logic [IDX_BITS-1:0]  idx_q, idx_d;
  logic [IDX_BITS-1:0]  limit_q, limit_d;
  logic                 rd_v_q, rd_v_d;
  logic [ADDR_BITS-1:0] rd_idx_q, rd_idx_d;
  logic                 insert_q, hit_q, hit_d, evict_q, evict_d;
  logic [ADDR_BITS-1:0] dest_q, dest_d;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_W-1:0]    handle_q, length_q;

  logic                 out_valid_q;
  logic                 out_hit_q, out_evicted_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [DATA_W-1:0]    out_handle_q, out_length_q;

  logic [IDX_BITS-1:0]  eff_size;
  logic                 accept, issue, scan_done, out_free, cfg_write;
  logic                 store_we;
  entry_t               store_wdata, rdata, best_entry;
  scan_ctrl_t           scan_ctrl;
  logic                 match;
  logic [ADDR_BITS-1:0] best_idx;
  logic [COUNT_BITS-1:0] bumped;

  // Configuration port: single register, zero wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CACHE_SIZE);
  assign prdata    = (paddr[2] == REG_CACHE_SIZE) ?
                     {{(APB_DW-CSIZE_W){1'b0}}, size_cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= CSIZE_W'(16);
    end else if (cfg_write) begin
      size_cfg_q <= pwdata[CSIZE_W-1:0];
    end
  end

  // Effective size: zero acts as one, anything above the capacity as the capacity.
  always_comb begin
    if (size_cfg_q == '0) begin
      eff_size = IDX_BITS'(1);
    end else if (int'(size_cfg_q) > CAPACITY) begin
      eff_size = IDX_BITS'(CAPACITY);
    end else begin
      eff_size = IDX_BITS'(size_cfg_q);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Scan issue: one memory read per cycle, compared in the next cycle.
  assign issue     = (state_q == ST_SCAN) && (idx_q < limit_q);
  assign scan_done = (state_q == ST_SCAN) && !issue && !rd_v_q;

  // A read issued in the cycle of a hit lands during the write-back; it must not
  // replace the entry that was hit, so comparisons only count while scanning.
  assign scan_ctrl.cmp_en = rd_v_q && (state_q == ST_SCAN);
  assign scan_ctrl.insert = insert_q;
  assign scan_ctrl.first  = (rd_idx_q == '0);
  assign scan_ctrl.idx    = rd_idx_q;

  lfu_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (dest_q),
    .wdata_i (store_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[ADDR_BITS-1:0]),
    .rdata_o (rdata)
  );

  lfu_scan u_scan (
    .clk_i        (clk_i),
    .ctrl_i       (scan_ctrl),
    .key_i        (key_q),
    .entry_i      (rdata),
    .match_o      (match),
    .best_idx_o   (best_idx),
    .best_entry_o (best_entry)
  );

  // Saturating use count of the entry that was hit.
  assign bumped = (best_entry.count == '1) ? best_entry.count : best_entry.count + 1'b1;

  always_comb begin
    store_wdata = '0;
    if (hit_q) begin
      store_wdata        = best_entry;
      store_wdata.count  = bumped;
    end else begin
      store_wdata.key    = key_q;
      store_wdata.handle = handle_q;
      store_wdata.length = length_q;
      store_wdata.count  = '0;
    end
  end

  assign store_we = (state_q == ST_WR) && out_free && (hit_q || insert_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    evict_d     = evict_q;
    dest_d      = dest_q;
    valid_cnt_d = valid_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hit_d   = 1'b0;
          evict_d = 1'b0;
          idx_d   = '0;
          if (req_i.action == ACT_INSERT && valid_cnt_q < eff_size) begin
            dest_d  = valid_cnt_q[ADDR_BITS-1:0];
            state_d = ST_WR;
          end else begin
            limit_d = (req_i.action == ACT_INSERT) ? eff_size : valid_cnt_q;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d    = idx_q + 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = idx_q[ADDR_BITS-1:0];
        end
        if (match) begin
          hit_d   = 1'b1;
          dest_d  = rd_idx_q;
          state_d = ST_WR;
        end else if (scan_done) begin
          if (insert_q) begin
            evict_d = 1'b1;
            dest_d  = best_idx;
          end else begin
            dest_d  = '0;
          end
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        if (out_free) begin
          if (insert_q && !evict_q) begin
            valid_cnt_d = valid_cnt_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_cnt_q <= '0;
      rd_v_q      <= 1'b0;
      hit_q       <= 1'b0;
      evict_q     <= 1'b0;
      idx_q       <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      valid_cnt_q <= valid_cnt_d;
      rd_v_q      <= rd_v_d;
      hit_q       <= hit_d;
      evict_q     <= evict_d;
      idx_q       <= idx_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    dest_q   <= dest_d;
    if (accept) begin
      insert_q <= (req_i.action == ACT_INSERT);
      key_q    <= req_i.key[KEY_BITS-1:0];
      handle_q <= req_i.content_handle;
      length_q <= req_i.content_length;
    end
  end

  // Output register; the result is loaded as the write-back state ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_WR && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WR && out_free) begin
      out_hit_q     <= hit_q;
      out_evicted_q <= evict_q;
      out_slot_q    <= SLOT_W'(dest_q);
      out_handle_q  <= hit_q ? best_entry.handle : '0;
      out_length_q  <= hit_q ? best_entry.length : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.slot          = out_slot_q;
  assign rsp_o.stored_handle = out_handle_q;
  assign rsp_o.stored_length = out_length_q;
  assign rsp_o.evicted       = out_evicted_q;

endmodule

### rtl/lfu_checker.sv
`include "assert_macros.svh"

module lfu_checker import lfu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_hit_i,
  input logic              rsp_evicted_i,
  input logic [DATA_W-1:0] rsp_handle_i,
  input logic [DATA_W-1:0] rsp_length_i
);

  // A waiting result stays offered until taken.
  `LFU_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  // The table works on one item at a time.
  `LFU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  // A hit never reports an eviction.
  `LFU_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, rsp_valid_i, !(rsp_hit_i && rsp_evicted_i))
  // Results without a hit carry an empty payload.
  `LFU_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, rsp_valid_i && !rsp_hit_i, rsp_handle_i == '0 && rsp_length_i == '0)

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_hit_i     (rsp_o.hit),
  .rsp_evicted_i (rsp_o.evicted),
  .rsp_handle_i  (rsp_o.stored_handle),
  .rsp_length_i  (rsp_o.stored_length)
);
